### rtl/mvsm_pkg.sv
// ----------------------------------------------------------------------------
// Multi-voice sample mixer package
// Shared types for the mixer: item layout, voice record, command and register
// codes, the request and response bundles of the iterative modulo unit and the
// operand widths of the shared multiplier.
// ----------------------------------------------------------------------------
package mvsm_pkg;

  // Iterative modulo unit operand widths.
  localparam int unsigned ModDvdW = 13;
  localparam int unsigned ModDivW = 17;

  // Shared multiplier operand widths (signed A, unsigned B).
  localparam int unsigned MulAW = 37;
  localparam int unsigned MulBW = 20;
  localparam int unsigned MulPW = MulAW + MulBW + 1;

  // Voice position width, Q13.16 frames.
  localparam int unsigned PosW = 29;

  // Command codes carried on the slave stream tuser.
  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_START  = 2'd1,
    CMD_RENDER = 2'd2,
    CMD_UNUSED = 2'd3
  } mvsm_cmd_e;

  // Master gain register indexes.
  typedef enum logic [1:0] {
    REG_MUSIC_L  = 2'd0,
    REG_MUSIC_R  = 2'd1,
    REG_EFFECT_L = 2'd2,
    REG_EFFECT_R = 2'd3
  } mvsm_reg_e;

  typedef struct packed {
    logic                 start;
    logic [ModDvdW-1:0]   dividend;
    logic [ModDivW-1:0]   divisor;
  } mvsm_mod_req_t;

  typedef struct packed {
    logic                 done;
    logic [ModDivW-1:0]   rem;
  } mvsm_mod_rsp_t;

  // Input item as packed on the slave stream, last field (addr) in the lowest bits.
  typedef struct packed {
    logic [5:0]   pad;
    logic [11:0]  frame_advance;
    logic [6:0]   samples_to_write;
    logic         is_music;
    logic         looping;
    logic [15:0]  gain_right;
    logic [15:0]  gain_left;
    logic [19:0]  step;
    logic [12:0]  voice_length;
    logic [15:0]  load_right;
    logic [15:0]  load_left;
    logic [11:0]  addr;
  } mvsm_item_t;

  // Per-voice playback record.
  typedef struct packed {
    logic [PosW-1:0]  pos;
    logic [19:0]      step;
    logic [11:0]      base;
    logic [12:0]      frames;
    logic [15:0]      gain_r;
    logic [15:0]      gain_l;
    logic             loop;
    logic             music;
  } mvsm_voice_t;

endpackage

### rtl/multi_voice_sample_mixer.sv
// A load goes through the modulo unit when SAMPLE_DEPTH is not a power of two. A render
// handles each output voice by voice and skips silent voices; each sounding voice uses the
// modulo unit and seven passes through the shared multiplier, and the output can stall on
// m_axis_tready. A position update of every active voice follows the last output.
// One item at a time; the input
// waits until it is done. Reset frees all voices and sets the master gains to 1.0.
// ----------------------------------------------------------------------------
// Multi-voice sample mixer
// Stereo sample memory with a bank of playback voices. Render items mix all
// sounding voices with linear interpolation and per-voice and master gains,
// one voice at a time through a shared multiplier and modulo unit.
// ----------------------------------------------------------------------------
module multi_voice_sample_mixer #(
  parameter int unsigned VOICES        = 16,
  parameter int unsigned SAMPLE_DEPTH  = 4096,
  parameter int unsigned MAX_FRAME_OUT = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // addr, load_left, load_right, voice_length, step, gain_left, gain_right,
  // looping, is_music, samples_to_write, frame_advance, zero fill
  input  logic [135:0]  s_axis_tdata,
  // cmd
  input  logic [1:0]    s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // out_left, out_right
  output logic [31:0]   m_axis_tdata,
  output logic          m_axis_tlast,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [15:0]   cfg_data_i
);
  import mvsm_pkg::*;

  localparam int unsigned VW        = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int unsigned AW        = $clog2(SAMPLE_DEPTH);
  localparam bit          DepthPow2 = ((SAMPLE_DEPTH & (SAMPLE_DEPTH - 1)) == 0);
  localparam int unsigned AccW      = MulAW + VW;
  localparam int unsigned QW        = AccW - 15;

  typedef enum logic [21:0] {
    ST_IDLE  = 22'h000001,
    ST_CMD   = 22'h000002,
    ST_LDMOD = 22'h000004,
    ST_VRD   = 22'h000008,
    ST_VCHK  = 22'h000010,
    ST_VKS   = 22'h000020,
    ST_VM0   = 22'h000040,
    ST_VA0   = 22'h000080,
    ST_VA1   = 22'h000100,
    ST_MRD0  = 22'h000200,
    ST_MRD1  = 22'h000400,
    ST_MCAP  = 22'h000800,
    ST_CD    = 22'h001000,
    ST_CV    = 22'h002000,
    ST_CG    = 22'h004000,
    ST_CT    = 22'h008000,
    ST_CM    = 22'h010000,
    ST_CU    = 22'h020000,
    ST_EMIT  = 22'h040000,
    ST_ARD   = 22'h080000,
    ST_ACHK  = 22'h100000,
    ST_AUPD  = 22'h200000
  } state_e;

  state_e                   state_q, state_d;
  mvsm_item_t               item_q;
  // Command code of the item being worked on.
  logic [1:0]               s_axis_tuser_q;
  logic [6:0]               k_q, k_d, n_q, n_d;
  logic [VW-1:0]            v_q, v_d;
  logic                     ch_q, ch_d;
  logic [VOICES-1:0]        active_q, active_d;
  logic signed [AccW-1:0]   accl_q, accl_d, accr_q, accr_d;
  logic [15:0]              f_q, f_d;
  logic [12:0]              m1_q, m1_d;
  logic [AW-1:0]            a0_q, a0_d, a1_q, a1_d;
  logic [31:0]              s0_q, s0_d, s1_q, s1_d;
  logic signed [32:0]       ip_q, ip_d;
  logic signed [MulAW-1:0]  t_q, t_d;
  logic                     out_valid_q;
  logic [15:0]              out_l_q, out_r_q;
  logic                     out_last_q;
  logic [15:0]              master_q [4];

  // Memories.
  logic [31:0]              smem [SAMPLE_DEPTH];
  logic [31:0]              srd_q;
  logic                     sm_we;
  logic [AW-1:0]            sm_wa, sm_ra;
  mvsm_voice_t              vmem [VOICES];
  mvsm_voice_t              vrec_q, vm_wd;
  logic                     vm_we;
  logic [VW-1:0]            vm_wa;

  // Shared units.
  mvsm_mod_req_t            mod_req;
  mvsm_mod_rsp_t            mod_rsp;
  logic signed [MulAW-1:0]  mul_a;
  logic [MulBW-1:0]         mul_b;
  logic signed [MulPW-1:0]  prod;
  logic signed [MulPW-1:0]  prod_rnd;
  logic signed [MulPW-1:0]  prod_sh;

  // Datapath helpers.
  logic                     in_acc, emit_go, free_found;
  logic [VW-1:0]            free_idx;
  logic [29:0]              rp_sum, p_sum;
  logic [13:0]              rp;
  logic [12:0]              remf, lim, mc, m1c;
  logic [13:0]              mp1;
  logic                     contrib, last_voice;
  logic [12:0]              sum_m0, sum_m1, sum_m1q;
  logic [15:0]              s0c, s1c, gain_c, master_c;
  logic signed [16:0]       diff;
  logic [32:0]              np;
  logic                     over;
  logic [6:0]               n_cap;

  // Rounded half even and saturated mix result.
  function automatic logic [15:0] finish16(input logic signed [AccW-1:0] acc);
    logic signed [QW-1:0] q;
    logic [15:0]          r;
    q = QW'(acc >>> 16);
    r = acc[15:0];
    if (r > 16'h8000 || (r == 16'h8000 && q[0])) begin
      q = q + QW'(1);
    end
    if (q > 32767) begin
      return 16'h7fff;
    end else if (q < -32768) begin
      return 16'h8000;
    end
    return q[15:0];
  endfunction

  mvsm_mod_div u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  mvsm_mult u_mult (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign emit_go       = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready);

  // Lowest free voice.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (!active_q[i]) begin
        free_found = 1'b1;
        free_idx   = VW'(i);
      end
    end
  end

  // Voice limit, interpolation position and wrapped frame indexes.
  always_comb begin
    rp_sum     = 30'(vrec_q.pos) + 30'h8000;
    rp         = rp_sum[29:16];
    remf       = ({1'b0, vrec_q.frames} > rp) ? 13'({1'b0, vrec_q.frames} - rp) : 13'd0;
    lim        = {remf[12:2], 2'b00};
    contrib    = active_q[v_q] && (vrec_q.loop || ({6'b0, k_q} < lim));
    last_voice = (v_q == VW'(VOICES - 1));
    p_sum      = 30'(vrec_q.pos) + prod[29:0];
    mc         = mod_rsp.rem[12:0];
    mp1        = {1'b0, mc} + 14'd1;
    m1c        = (mp1 == {1'b0, vrec_q.frames}) ? 13'd0 : mp1[12:0];
    sum_m0     = 13'(vrec_q.base) + mc;
    sum_m1     = 13'(vrec_q.base) + m1c;
    sum_m1q    = 13'(vrec_q.base) + m1_q;
    s0c        = ch_q ? s0_q[31:16] : s0_q[15:0];
    s1c        = ch_q ? s1_q[31:16] : s1_q[15:0];
    diff       = $signed({s1c[15], s1c}) - $signed({s0c[15], s0c});
    gain_c     = ch_q ? vrec_q.gain_r : vrec_q.gain_l;
    if (vrec_q.music) begin
      master_c = ch_q ? master_q[REG_MUSIC_R] : master_q[REG_MUSIC_L];
    end else begin
      master_c = ch_q ? master_q[REG_EFFECT_R] : master_q[REG_EFFECT_L];
    end
    prod_rnd   = prod + MulPW'(8192);
    prod_sh    = prod_rnd >>> 14;
    np         = 33'(vrec_q.pos) + prod[32:0];
    over       = np > {4'b0, vrec_q.frames, 16'h0000};
    n_cap      = (item_q.samples_to_write > 7'(MAX_FRAME_OUT)) ?
                 7'(MAX_FRAME_OUT) : item_q.samples_to_write;
  end

  // Sequencer.
  always_comb begin
    state_d  = state_q;
    k_d      = k_q;
    n_d      = n_q;
    v_d      = v_q;
    ch_d     = ch_q;
    active_d = active_q;
    accl_d   = accl_q;
    accr_d   = accr_q;
    f_d      = f_q;
    m1_d     = m1_q;
    a0_d     = a0_q;
    a1_d     = a1_q;
    s0_d     = s0_q;
    s1_d     = s1_q;
    ip_d     = ip_q;
    t_d      = t_q;
    mod_req  = '{start: 1'b0, dividend: '0, divisor: '0};
    mul_a    = '0;
    mul_b    = '0;
    sm_we    = 1'b0;
    sm_wa    = AW'(item_q.addr);
    vm_we    = 1'b0;
    vm_wa    = v_q;
    vm_wd    = vrec_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_CMD;
        end
      end
      ST_CMD: begin
        state_d = ST_IDLE;
        case (s_axis_tuser_q)
          CMD_LOAD: begin
            if (DepthPow2) begin
              sm_we = 1'b1;
            end else begin
              mod_req = '{start: 1'b1, dividend: 13'(item_q.addr),
                          divisor: 17'(SAMPLE_DEPTH)};
              state_d = ST_LDMOD;
            end
          end
          CMD_START: begin
            if (item_q.voice_length != 13'd0 && free_found) begin
              vm_we            = 1'b1;
              vm_wa            = free_idx;
              vm_wd.pos        = '0;
              vm_wd.step       = item_q.step;
              vm_wd.base       = item_q.addr;
              vm_wd.frames     = item_q.voice_length;
              vm_wd.gain_l     = item_q.gain_left;
              vm_wd.gain_r     = item_q.gain_right;
              vm_wd.loop       = item_q.looping;
              vm_wd.music      = item_q.is_music;
              active_d[free_idx] = 1'b1;
            end
          end
          CMD_RENDER: begin
            n_d    = {n_cap[6:2], 2'b00};
            k_d    = '0;
            v_d    = '0;
            ch_d   = 1'b0;
            accl_d = '0;
            accr_d = '0;
            state_d = (n_cap[6:2] == 5'd0) ? ST_ARD : ST_VRD;
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_LDMOD: begin
        if (mod_rsp.done) begin
          sm_we   = 1'b1;
          sm_wa   = AW'(mod_rsp.rem);
          state_d = ST_IDLE;
        end
      end
      ST_VRD: begin
        state_d = ST_VCHK;
      end
      ST_VCHK: begin
        mul_a = MulAW'(vrec_q.step);
        mul_b = MulBW'(k_q);
        if (contrib) begin
          state_d = ST_VKS;
        end else if (last_voice) begin
          state_d = ST_EMIT;
        end else begin
          v_d     = v_q + VW'(1);
          state_d = ST_VRD;
        end
      end
      ST_VKS: begin
        f_d     = p_sum[15:0];
        mod_req = '{start: 1'b1, dividend: p_sum[28:16], divisor: 17'(vrec_q.frames)};
        state_d = ST_VM0;
      end
      ST_VM0: begin
        if (mod_rsp.done) begin
          m1_d = m1c;
          if (DepthPow2) begin
            a0_d    = AW'(sum_m0);
            a1_d    = AW'(sum_m1);
            state_d = ST_MRD0;
          end else begin
            mod_req = '{start: 1'b1, dividend: sum_m0, divisor: 17'(SAMPLE_DEPTH)};
            state_d = ST_VA0;
          end
        end
      end
      ST_VA0: begin
        if (mod_rsp.done) begin
          a0_d    = AW'(mod_rsp.rem);
          mod_req = '{start: 1'b1, dividend: sum_m1q, divisor: 17'(SAMPLE_DEPTH)};
          state_d = ST_VA1;
        end
      end
      ST_VA1: begin
        if (mod_rsp.done) begin
          a1_d    = AW'(mod_rsp.rem);
          state_d = ST_MRD0;
        end
      end
      ST_MRD0: begin
        state_d = ST_MRD1;
      end
      ST_MRD1: begin
        s0_d    = srd_q;
        state_d = ST_MCAP;
      end
      ST_MCAP: begin
        s1_d    = srd_q;
        ch_d    = 1'b0;
        state_d = ST_CD;
      end
      ST_CD: begin
        mul_a   = MulAW'(diff);
        mul_b   = MulBW'(f_q);
        state_d = ST_CV;
      end
      ST_CV: begin
        ip_d    = $signed({s0c[15], s0c, 16'h0000}) + $signed(prod[32:0]);
        state_d = ST_CG;
      end
      ST_CG: begin
        mul_a   = MulAW'(ip_q);
        mul_b   = MulBW'(gain_c);
        state_d = ST_CT;
      end
      ST_CT: begin
        t_d     = MulAW'(prod_sh);
        state_d = ST_CM;
      end
      ST_CM: begin
        mul_a   = t_q;
        mul_b   = MulBW'(master_c);
        state_d = ST_CU;
      end
      ST_CU: begin
        if (!ch_q) begin
          accl_d  = accl_q + AccW'(prod_sh);
          ch_d    = 1'b1;
          state_d = ST_CD;
        end else begin
          accr_d = accr_q + AccW'(prod_sh);
          if (last_voice) begin
            state_d = ST_EMIT;
          end else begin
            v_d     = v_q + VW'(1);
            state_d = ST_VRD;
          end
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          k_d    = k_q + 7'd1;
          v_d    = '0;
          accl_d = '0;
          accr_d = '0;
          state_d = (k_q == n_q - 7'd1) ? ST_ARD : ST_VRD;
        end
      end
      ST_ARD: begin
        state_d = ST_ACHK;
      end
      ST_ACHK: begin
        mul_a = MulAW'(vrec_q.step);
        mul_b = MulBW'(item_q.frame_advance);
        if (active_q[v_q]) begin
          state_d = ST_AUPD;
        end else if (last_voice) begin
          state_d = ST_IDLE;
        end else begin
          v_d     = v_q + VW'(1);
          state_d = ST_ARD;
        end
      end
      ST_AUPD: begin
        vm_we = 1'b1;
        if (over) begin
          vm_wd.pos = '0;
          if (!vrec_q.loop) begin
            active_d[v_q] = 1'b0;
          end
        end else begin
          vm_wd.pos = np[PosW-1:0];
        end
        if (last_voice) begin
          state_d = ST_IDLE;
        end else begin
          v_d     = v_q + VW'(1);
          state_d = ST_ARD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      n_q         <= '0;
      v_q         <= '0;
      ch_q        <= 1'b0;
      active_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      k_q      <= k_d;
      n_q      <= n_d;
      v_q      <= v_d;
      ch_q     <= ch_d;
      active_q <= active_d;
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Master gain registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        master_q[i] <= 16'd16384;
      end
    end else if (cfg_we_i) begin
      master_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q         <= mvsm_item_t'(s_axis_tdata);
      s_axis_tuser_q <= s_axis_tuser;
    end
    accl_q <= accl_d;
    accr_q <= accr_d;
    f_q    <= f_d;
    m1_q   <= m1_d;
    a0_q   <= a0_d;
    a1_q   <= a1_d;
    s0_q   <= s0_d;
    s1_q   <= s1_d;
    ip_q   <= ip_d;
    t_q    <= t_d;
    if (emit_go) begin
      out_l_q    <= finish16(accl_q);
      out_r_q    <= finish16(accr_q);
      out_last_q <= (k_q == n_q - 7'd1);
    end
  end

  // Sample memory, registered read.
  assign sm_ra = (state_q == ST_MRD0) ? a0_q : a1_q;

  always_ff @(posedge clk_i) begin
    if (sm_we) begin
      smem[sm_wa] <= {item_q.load_right, item_q.load_left};
    end
    srd_q <= smem[sm_ra];
  end

  // Voice record memory, registered read of the current voice.
  always_ff @(posedge clk_i) begin
    if (vm_we) begin
      vmem[vm_wa] <= vm_wd;
    end
    vrec_q <= vmem[v_q];
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_r_q, out_l_q};
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
  // An emitted item always lies inside the render block.
  a_emit_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (k_q < n_q))
    else $error("emit outside render block");

  // The final item of a render hands over to the position update.
  a_last_to_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_go && (k_q == n_q - 7'd1)) |=> (state_q == ST_ARD))
    else $error("render end did not start position update");

  // An inactive voice never reaches the interpolation path.
  a_skip_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_VCHK && !active_q[v_q]) |=> (state_q != ST_VKS))
    else $error("inactive voice mixed");
`endif

endmodule

### rtl/mvsm_mod_div.sv
// ----------------------------------------------------------------------------
// Iterative modulo unit
// Restoring division that retires one dividend bit per cycle and returns the
// remainder; a done flag pulses for one cycle when the remainder is ready.
// ----------------------------------------------------------------------------
module mvsm_mod_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mvsm_pkg::mvsm_mod_req_t req_i,
  output mvsm_pkg::mvsm_mod_rsp_t rsp_o
);
  import mvsm_pkg::*;

  localparam int unsigned CntW = $clog2(ModDvdW + 1);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [ModDvdW-1:0]  dvd_q, dvd_d;
  logic [ModDivW-1:0]  div_q, div_d;
  logic [ModDivW-1:0]  rem_q, rem_d;
  logic [ModDivW:0]    trial;

  // One shift-and-subtract step per cycle.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    trial  = {rem_q, dvd_q[ModDvdW-1]};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = req_i.dividend;
      div_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d = ModDivW'(trial - {1'b0, div_q});
      end else begin
        rem_d = trial[ModDivW-1:0];
      end
      dvd_d = dvd_q << 1;
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(ModDvdW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand and remainder registers.
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

### rtl/mvsm_mult.sv
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed by unsigned multiplier with a registered product, shared by every
// multiplication of the mixer under control of the sequencer.
// ----------------------------------------------------------------------------
module mvsm_mult (
  input  logic                                clk_i,
  input  logic signed [mvsm_pkg::MulAW-1:0]   a_i,
  input  logic        [mvsm_pkg::MulBW-1:0]   b_i,
  output logic signed [mvsm_pkg::MulPW-1:0]   p_o
);
  import mvsm_pkg::*;

  logic signed [MulBW:0]    b_ext;
  logic signed [MulPW-1:0]  p_q;

  assign b_ext = $signed({1'b0, b_i});

  // Product register.
  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_ext;
  end

  assign p_o = p_q;

endmodule
